// ----- src/cdclk_pkg.sv -----
package cdclk_pkg;

	localparam int FRAC_W    = 32;
	localparam int INC_W     = 40;
	localparam int YEAR_W    = 24;
	localparam int MONTH_W   = 4;
	localparam int DOM_W     = 5;
	localparam int WDAY_W    = 3;
	localparam int HOUR_W    = 5;
	localparam int MIN_W     = 6;
	localparam int SEC_W     = 6;
	localparam int MS_W      = 10;
	localparam int DOY_W     = 9;
	localparam int FLAGS_W   = 4;

	localparam int NUM_MONTHS    = 12;
	localparam int YEAR_DAYS     = 365;
	localparam int DAYS_PER_WEEK = 7;
	localparam int HOURS_PER_DAY = 24;
	localparam int MIN_PER_HOUR  = 60;
	localparam int SEC_PER_MIN   = 60;
	localparam int MS_PER_SEC    = 1000;

	// floor(2^40 / 365); quotient estimate is low by at most one
	localparam int                RECIP_SHIFT = 40;
	localparam logic [31:0]       RECIP_365   = 32'd3012360624;

	localparam int FLAG_DAY   = 0;
	localparam int FLAG_WEEK  = 1;
	localparam int FLAG_MONTH = 2;
	localparam int FLAG_YEAR  = 3;

	localparam logic [DOY_W-1:0] MONTH_START [NUM_MONTHS] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_LOAD = 1'b1
	} cmd_t;

	typedef enum logic {
		CFG_PAUSED          = 1'b0,
		CFG_DAYS_PER_SECOND = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic update;
	} acc_ctl_t;

	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} stage_ld_t;

	function automatic logic [MONTH_W-1:0] month_of(input logic [DOY_W-1:0] doy);
		logic [MONTH_W-1:0] m;
		m = '0;
		for (int i = 1; i < NUM_MONTHS; i++)
			if (doy >= MONTH_START[i])
				m = MONTH_W'(i);
		return m;
	endfunction

endpackage

// ----- src/calendar_day_clock.sv -----
// Game calendar clock: day number plus a 0.32 fraction of the day, no leap years.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the paused bit
// and the days-per-second rate; cfg_ready is always high. Write it while idle.
// Input channel (in_valid/in_ready): command 0 ticks by delta_time times the
// rate, command 1 loads load_day and load_time_of_day.
// Output channel (out_valid/out_ready): one beat per input beat, in order, with
// event flags, date, weekday and time of day.
// Throughput: one beat per cycle while the receiver does not stall. A beat passes
// registers s1 to s5 and the output register; the depth comes from the divide by
// 365 (reciprocal multiply, constant multiply, correction) and the 24/60/60/1000
// time-of-day chain. Day and fraction accumulate in a register loop at stage s2.
// Reset: paused 1, rate 0, day 0, fraction 0, pipeline empty.
// Receiver stall: the output beat holds, earlier stages keep filling, and
// in_ready drops only when every stage holds a beat.
module calendar_day_clock
	import cdclk_pkg::*;
#(
	parameter int DAY_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [31:0]        delta_time,
	input  logic [31:0]        load_day,
	input  logic [31:0]        load_time_of_day,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [FLAGS_W-1:0] event_flags,
	output logic [YEAR_W-1:0]  year,
	output logic [MONTH_W-1:0] month,
	output logic [DOM_W-1:0]   day_of_month,
	output logic [WDAY_W-1:0]  day_of_week,
	output logic [HOUR_W-1:0]  hour,
	output logic [MIN_W-1:0]   minute,
	output logic [SEC_W-1:0]   second,
	output logic [MS_W-1:0]    millisecond
);

	logic                paused_q;
	logic [31:0]         dps_q;

	logic                valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic                out_valid_q;
	logic                nd_s3, nd_s4, nd_s5;
	logic                ld_s1, ld_s2, ld_out;
	stage_ld_t           ld;
	acc_ctl_t            acc_ctl;

	logic [DAY_BITS-1:0] day_q;
	logic [FRAC_W-1:0]   frac_q;
	logic                new_day_s2;

	logic [YEAR_W-1:0]   cal_year;
	logic [MONTH_W-1:0]  cal_month;
	logic [DOM_W-1:0]    cal_dom;
	logic [WDAY_W-1:0]   cal_wday;
	logic [HOUR_W-1:0]   tod_hour;
	logic [MIN_W-1:0]    tod_minute;
	logic [SEC_W-1:0]    tod_second;
	logic [MS_W-1:0]     tod_ms;
	logic [FLAGS_W-1:0]  flags_next;

	logic [FLAGS_W-1:0]  flags_q;
	logic [YEAR_W-1:0]   year_q;
	logic [MONTH_W-1:0]  month_q;
	logic [DOM_W-1:0]    dom_q;
	logic [WDAY_W-1:0]   wday_q;
	logic [HOUR_W-1:0]   hour_q;
	logic [MIN_W-1:0]    minute_q;
	logic [SEC_W-1:0]    second_q;
	logic [MS_W-1:0]     ms_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paused_q <= 1'b1;
			dps_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_PAUSED:          paused_q <= cfg_data[0];
				CFG_DAYS_PER_SECOND: dps_q    <= cfg_data;
			endcase
		end
	end

	always_comb begin
		ld_out          = !out_valid_q || out_ready;
		ld.s5           = !valid_s5 || ld_out;
		ld.s4           = !valid_s4 || ld.s5;
		ld.s3           = !valid_s3 || ld.s4;
		ld_s2           = !valid_s2 || ld.s3;
		ld_s1           = !valid_s1 || ld_s2;
		acc_ctl.load_s1 = ld_s1 && in_valid;
		acc_ctl.load_s2 = ld_s2;
		acc_ctl.update  = ld_s2 && valid_s1;
	end

	assign in_ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1)
				valid_s1 <= in_valid;
			if (ld_s2)
				valid_s2 <= valid_s1;
			if (ld.s3)
				valid_s3 <= valid_s2;
			if (ld.s4)
				valid_s4 <= valid_s3;
			if (ld.s5)
				valid_s5 <= valid_s4;
			if (ld_out)
				out_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s3)
			nd_s3 <= new_day_s2;
		if (ld.s4)
			nd_s4 <= nd_s3;
		if (ld.s5)
			nd_s5 <= nd_s4;
	end

	cdclk_acc #(
		.DAY_BITS (DAY_BITS)
	) u_acc (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (acc_ctl),
		.command          (command),
		.delta_time       (delta_time),
		.load_day         (load_day),
		.load_time_of_day (load_time_of_day),
		.paused           (paused_q),
		.days_per_second  (dps_q),
		.day_q            (day_q),
		.frac_q           (frac_q),
		.new_day_s2       (new_day_s2)
	);

	cdclk_date #(
		.DAY_BITS (DAY_BITS)
	) u_date (
		.clk          (clk),
		.ld           (ld),
		.day          (day_q),
		.year         (cal_year),
		.month        (cal_month),
		.day_of_month (cal_dom),
		.day_of_week  (cal_wday)
	);

	cdclk_tod u_tod (
		.clk         (clk),
		.ld          (ld),
		.frac        (frac_q),
		.hour        (tod_hour),
		.minute      (tod_minute),
		.second      (tod_second),
		.millisecond (tod_ms)
	);

	// year_q and month_q hold the date of the previous beat
	always_comb begin
		flags_next             = '0;
		flags_next[FLAG_DAY]   = nd_s5;
		flags_next[FLAG_WEEK]  = nd_s5 && (cal_wday == '0);
		flags_next[FLAG_MONTH] = nd_s5 && (cal_month != month_q);
		flags_next[FLAG_YEAR]  = nd_s5 && (cal_year != year_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q  <= YEAR_W'(1);
			month_q <= '0;
		end else if (ld_out && valid_s5) begin
			year_q  <= cal_year;
			month_q <= cal_month;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out && valid_s5) begin
			flags_q  <= flags_next;
			dom_q    <= cal_dom;
			wday_q   <= cal_wday;
			hour_q   <= tod_hour;
			minute_q <= tod_minute;
			second_q <= tod_second;
			ms_q     <= tod_ms;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_flags  = flags_q;
	assign year         = year_q;
	assign month        = month_q;
	assign day_of_month = dom_q;
	assign day_of_week  = wday_q;
	assign hour         = hour_q;
	assign minute       = minute_q;
	assign second       = second_q;
	assign millisecond  = ms_q;

endmodule

// ----- src/cdclk_acc.sv -----
module cdclk_acc
	import cdclk_pkg::*;
#(
	parameter int DAY_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  acc_ctl_t            ctl,
	input  logic                command,
	input  logic [31:0]         delta_time,
	input  logic [31:0]         load_day,
	input  logic [31:0]         load_time_of_day,
	input  logic                paused,
	input  logic [31:0]         days_per_second,
	output logic [DAY_BITS-1:0] day_q,
	output logic [FRAC_W-1:0]   frac_q,
	output logic                new_day_s2
);

	localparam int PROD_W = 2 * FRAC_W;
	localparam int SUM_W  = INC_W + 1;

	cmd_t                cmd_s1;
	logic [INC_W-1:0]    inc_s1;
	logic [DAY_BITS-1:0] load_day_s1;
	logic [FRAC_W-1:0]   load_tod_s1;

	logic [PROD_W-1:0]   prod;
	logic [SUM_W-1:0]    sum;
	logic                tick_go;
	logic                rollover;
	logic [FRAC_W-1:0]   frac_tick;
	logic [DAY_BITS-1:0] day_next;
	logic [FRAC_W-1:0]   frac_next;

	assign prod = PROD_W'(delta_time) * PROD_W'(days_per_second);

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			cmd_s1      <= cmd_t'(command);
			inc_s1      <= prod[PROD_W-1:PROD_W-INC_W];
			load_day_s1 <= load_day[DAY_BITS-1:0];
			load_tod_s1 <= load_time_of_day;
		end
	end

	assign sum       = SUM_W'(frac_q) + SUM_W'(inc_s1);
	assign tick_go   = (cmd_s1 == CMD_TICK) && !paused;
	assign rollover  = tick_go && (sum[SUM_W-1:FRAC_W] != '0);
	// one rollover at most; a sum of two days or more saturates the fraction
	assign frac_tick = (sum[SUM_W-1:FRAC_W+1] != '0) ? '1 : sum[FRAC_W-1:0];

	always_comb begin
		day_next  = day_q;
		frac_next = frac_q;
		if (cmd_s1 == CMD_LOAD) begin
			day_next  = load_day_s1;
			frac_next = load_tod_s1;
		end else if (tick_go) begin
			frac_next = frac_tick;
			if (rollover)
				day_next = day_q + DAY_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q  <= '0;
			frac_q <= '0;
		end else if (ctl.update) begin
			day_q  <= day_next;
			frac_q <= frac_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2)
			new_day_s2 <= rollover;
	end

endmodule

// ----- src/cdclk_date.sv -----
module cdclk_date
	import cdclk_pkg::*;
#(
	parameter int DAY_BITS = 32
) (
	input  logic                clk,
	input  stage_ld_t           ld,
	input  logic [DAY_BITS-1:0] day,
	output logic [YEAR_W-1:0]   year,
	output logic [MONTH_W-1:0]  month,
	output logic [DOM_W-1:0]    day_of_month,
	output logic [WDAY_W-1:0]   day_of_week
);

	localparam int PW     = DAY_BITS + 32;
	localparam int QW     = PW - RECIP_SHIFT;
	localparam int NCH    = (DAY_BITS + 2) / 3;
	localparam int PAD_W  = 3 * NCH;
	localparam int FOLD_W = $clog2(7 * NCH + 1);
	localparam int NF     = (FOLD_W + 2) / 3;
	localparam int FPAD_W = 3 * NF;
	localparam int WS_W   = $clog2(3 * DAYS_PER_WEEK + 1);

	logic [DAY_BITS-1:0] day_s3;
	logic [PW-1:0]       prod_s3;
	logic [FOLD_W-1:0]   fold_s3;

	logic [DAY_BITS-1:0] day_s4;
	logic [QW-1:0]       qe_s4;
	logic [DAY_BITS-1:0] q365_s4;
	logic [WDAY_W-1:0]   wday_s4;

	logic [YEAR_W-1:0]   year_s5;
	logic [DOY_W-1:0]    doy_s5;
	logic [WDAY_W-1:0]   wday_s5;

	logic [PAD_W-1:0]    day_pad;
	logic [FOLD_W-1:0]   fold_sum;
	logic [FPAD_W-1:0]   fold_pad;
	logic [WS_W-1:0]     wsum;
	logic [WDAY_W-1:0]   wday_next;
	logic [QW-1:0]       qe_next;
	logic [DAY_BITS-1:0] rem;
	logic [9:0]          rem10;
	logic                over;
	logic [QW-1:0]       q_fix;
	logic [DOY_W-1:0]    dom_wide;

	// 8 == 1 mod 7: sum the octal digits
	assign day_pad = PAD_W'(day);

	always_comb begin
		fold_sum = '0;
		for (int i = 0; i < NCH; i++)
			fold_sum = fold_sum + FOLD_W'(day_pad[3*i +: 3]);
	end

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			day_s3  <= day;
			prod_s3 <= PW'(day) * PW'(RECIP_365);
			fold_s3 <= fold_sum;
		end
	end

	assign fold_pad = FPAD_W'(fold_s3);
	assign qe_next  = prod_s3[PW-1:RECIP_SHIFT];

	always_comb begin
		wsum = '0;
		for (int i = 0; i < NF; i++)
			wsum = wsum + WS_W'(fold_pad[3*i +: 3]);
		priority if (wsum >= WS_W'(3 * DAYS_PER_WEEK))
			wday_next = WDAY_W'(wsum - WS_W'(3 * DAYS_PER_WEEK));
		else if (wsum >= WS_W'(2 * DAYS_PER_WEEK))
			wday_next = WDAY_W'(wsum - WS_W'(2 * DAYS_PER_WEEK));
		else if (wsum >= WS_W'(DAYS_PER_WEEK))
			wday_next = WDAY_W'(wsum - WS_W'(DAYS_PER_WEEK));
		else
			wday_next = WDAY_W'(wsum);
	end

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			day_s4  <= day_s3;
			qe_s4   <= qe_next;
			q365_s4 <= DAY_BITS'(qe_next) * DAY_BITS'(YEAR_DAYS);
			wday_s4 <= wday_next;
		end
	end

	// remainder below twice the year length: one correction step
	assign rem   = day_s4 - q365_s4;
	assign rem10 = rem[9:0];
	assign over  = rem10 >= 10'(YEAR_DAYS);
	assign q_fix = qe_s4 + QW'(over);

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			year_s5 <= YEAR_W'(q_fix) + YEAR_W'(1);
			doy_s5  <= over ? DOY_W'(rem10 - 10'(YEAR_DAYS)) : rem10[DOY_W-1:0];
			wday_s5 <= wday_s4;
		end
	end

	assign month        = month_of(doy_s5);
	assign dom_wide     = doy_s5 - MONTH_START[month] + DOY_W'(1);
	assign day_of_month = dom_wide[DOM_W-1:0];
	assign year         = year_s5;
	assign day_of_week  = wday_s5;

endmodule

// ----- src/cdclk_tod.sv -----
module cdclk_tod
	import cdclk_pkg::*;
(
	input  logic              clk,
	input  stage_ld_t         ld,
	input  logic [FRAC_W-1:0] frac,
	output logic [HOUR_W-1:0] hour,
	output logic [MIN_W-1:0]  minute,
	output logic [SEC_W-1:0]  second,
	output logic [MS_W-1:0]   millisecond
);

	localparam int T1_W = FRAC_W + HOUR_W;
	localparam int T2_W = FRAC_W + MIN_W;
	localparam int T3_W = FRAC_W + SEC_W;
	localparam int T4_W = FRAC_W + MS_W;

	logic [HOUR_W-1:0] hour_s3, hour_s4, hour_s5;
	logic [MIN_W-1:0]  minute_s4, minute_s5;
	logic [SEC_W-1:0]  second_s5;
	logic [FRAC_W-1:0] rem_s3, rem_s4, rem_s5;

	logic [T1_W-1:0]   t1;
	logic [T2_W-1:0]   t2;
	logic [T3_W-1:0]   t3;
	logic [T4_W-1:0]   t4;

	assign t1 = T1_W'(frac) * T1_W'(HOURS_PER_DAY);
	assign t2 = T2_W'(rem_s3) * T2_W'(MIN_PER_HOUR);
	assign t3 = T3_W'(rem_s4) * T3_W'(SEC_PER_MIN);
	assign t4 = T4_W'(rem_s5) * T4_W'(MS_PER_SEC);

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			hour_s3 <= t1[T1_W-1:FRAC_W];
			rem_s3  <= t1[FRAC_W-1:0];
		end
		if (ld.s4) begin
			hour_s4   <= hour_s3;
			minute_s4 <= t2[T2_W-1:FRAC_W];
			rem_s4    <= t2[FRAC_W-1:0];
		end
		if (ld.s5) begin
			hour_s5   <= hour_s4;
			minute_s5 <= minute_s4;
			second_s5 <= t3[T3_W-1:FRAC_W];
			rem_s5    <= t3[FRAC_W-1:0];
		end
	end

	assign hour        = hour_s5;
	assign minute      = minute_s5;
	assign second      = second_s5;
	assign millisecond = t4[T4_W-1:FRAC_W];

endmodule

// ----- src/cdclk_chk.sv -----
module cdclk_chk
	import cdclk_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [FLAGS_W-1:0] event_flags,
	input logic [YEAR_W-1:0]  year,
	input logic [MONTH_W-1:0] month,
	input logic [DOM_W-1:0]   day_of_month,
	input logic [WDAY_W-1:0]  day_of_week,
	input logic [HOUR_W-1:0]  hour,
	input logic [MIN_W-1:0]   minute,
	input logic [SEC_W-1:0]   second,
	input logic [MS_W-1:0]    millisecond
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_flags) && $stable(year)
			&& $stable(month) && $stable(day_of_month) && $stable(day_of_week)
			&& $stable(hour) && $stable(minute) && $stable(second)
			&& $stable(millisecond))
		else $error("output beat changed while stalled");

	a_week_on_monday: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_flags[FLAG_WEEK] |-> event_flags[FLAG_DAY] && day_of_week == '0)
		else $error("new week without a new day on Monday");

	a_month_on_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_flags[FLAG_MONTH] |-> event_flags[FLAG_DAY] && day_of_month == DOM_W'(1))
		else $error("new month off the first of the month");

	a_year_in_january: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_flags[FLAG_YEAR] |-> event_flags[FLAG_MONTH] && month == '0)
		else $error("new year without a new month in January");

endmodule

bind calendar_day_clock cdclk_chk u_cdclk_chk (.*);
